>>> rtl/core/sor_pkg.sv
// ----------------------------------------------------------------------------
// sor_pkg
// Shared types and constants of the segment overlap rasterizer: grid size,
// field widths, the input and result words and the internal status structs.
// ----------------------------------------------------------------------------
package sor_pkg;

  // grid geometry
  localparam int GridSide   = 1024;
  localparam int CellCount  = GridSide * GridSide;
  localparam int CellAddrW  = $clog2(CellCount);

  // field widths
  localparam int CoordW     = 10;
  localparam int CoverW     = 2;
  localparam int TotalW     = 21;

  // compare width wide enough for both a coordinate and the grid side
  localparam int CoordCmpW  = ((CoordW > $clog2(GridSide)) ? CoordW : $clog2(GridSide)) + 1;

  localparam logic [CoverW-1:0] CoverMax = {CoverW{1'b1}};
  localparam logic [CoverW-1:0] CoverOne = CoverW'(1);
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // action codes
  localparam logic ActDraw  = 1'b0;
  localparam logic ActClear = 1'b1;

  // input word
  typedef struct packed {
    logic              action;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
    logic [CoordW-1:0] end_x;
    logic [CoordW-1:0] end_y;
  } sor_in_t;

  // result word
  typedef struct packed {
    logic [TotalW-1:0] overlap_cells;
    logic              rejected;
  } sor_out_t;

  // current cell of the segment walker
  typedef struct packed {
    logic [CellAddrW-1:0] addr;
    logic                 last;
  } sor_walk_t;

  // status of the grid read-modify-write path
  typedef struct packed {
    logic wb_pending;
    logic hit_two;
  } sor_grid_stat_t;

endpackage

>>> rtl/core/sor_seg_walk.sv
// ----------------------------------------------------------------------------
// sor_seg_walk
// Checks a segment for slope and range and steps along its cells, one cell
// per advance, giving the linear grid address of the current cell.
// ----------------------------------------------------------------------------
module sor_seg_walk (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               adv_i,
  input  sor_pkg::sor_in_t   seg_i,
  output logic               rejected_o,
  output sor_pkg::sor_walk_t cell_o
);

  logic [sor_pkg::CoordW-1:0] dx;
  logic [sor_pkg::CoordW-1:0] dy;
  logic [sor_pkg::CoordW-1:0] steps;
  logic                       off_grid;
  logic                       bad_slope;

  logic [sor_pkg::CoordW-1:0] x_q, y_q, remain_q;
  logic                       x_inc_q, x_dec_q, y_inc_q, y_dec_q;

  // distances, step count and acceptance of the segment
  always_comb begin
    dx = (seg_i.start_x > seg_i.end_x) ? (seg_i.start_x - seg_i.end_x)
                                       : (seg_i.end_x - seg_i.start_x);
    dy = (seg_i.start_y > seg_i.end_y) ? (seg_i.start_y - seg_i.end_y)
                                       : (seg_i.end_y - seg_i.start_y);
    steps = (dx > dy) ? dx : dy;
    off_grid =
      (sor_pkg::CoordCmpW'(seg_i.start_x) >= sor_pkg::CoordCmpW'(sor_pkg::GridSide)) ||
      (sor_pkg::CoordCmpW'(seg_i.start_y) >= sor_pkg::CoordCmpW'(sor_pkg::GridSide)) ||
      (sor_pkg::CoordCmpW'(seg_i.end_x)   >= sor_pkg::CoordCmpW'(sor_pkg::GridSide)) ||
      (sor_pkg::CoordCmpW'(seg_i.end_y)   >= sor_pkg::CoordCmpW'(sor_pkg::GridSide));
    bad_slope = !((dx == '0) || (dy == '0) || (dx == dy));
    rejected_o = off_grid || bad_slope;
  end

  // walk position and direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
      x_inc_q  <= 1'b0;
      x_dec_q  <= 1'b0;
      y_inc_q  <= 1'b0;
      y_dec_q  <= 1'b0;
    end else if (load_i) begin
      remain_q <= steps;
      x_inc_q  <= seg_i.start_x < seg_i.end_x;
      x_dec_q  <= seg_i.start_x > seg_i.end_x;
      y_inc_q  <= seg_i.start_y < seg_i.end_y;
      y_dec_q  <= seg_i.start_y > seg_i.end_y;
    end else if (adv_i && remain_q != '0) begin
      remain_q <= remain_q - sor_pkg::CoordW'(1);
    end
  end

  // coordinates carry no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      x_q <= seg_i.start_x;
      y_q <= seg_i.start_y;
    end else if (adv_i) begin
      if (x_inc_q) begin
        x_q <= x_q + sor_pkg::CoordW'(1);
      end else if (x_dec_q) begin
        x_q <= x_q - sor_pkg::CoordW'(1);
      end
      if (y_inc_q) begin
        y_q <= y_q + sor_pkg::CoordW'(1);
      end else if (y_dec_q) begin
        y_q <= y_q - sor_pkg::CoordW'(1);
      end
    end
  end

  // linear cell address, row major
  always_comb begin
    cell_o.addr = sor_pkg::CellAddrW'(y_q) * sor_pkg::CellAddrW'(sor_pkg::GridSide) +
                  sor_pkg::CellAddrW'(x_q);
    cell_o.last = (remain_q == '0);
  end

endmodule

>>> rtl/core/sor_cover_grid.sv
// ----------------------------------------------------------------------------
// sor_cover_grid
// Grid of 2-bit cover counts in a synchronous memory. A cell read is
// followed in the next cycle by the saturating increment written back; a
// clear port writes zero to one cell per cycle.
// ----------------------------------------------------------------------------
module sor_cover_grid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [sor_pkg::CellAddrW-1:0] rd_addr_i,
  input  logic                          clr_en_i,
  input  logic [sor_pkg::CellAddrW-1:0] clr_addr_i,
  output sor_pkg::sor_grid_stat_t       stat_o
);

  logic [sor_pkg::CoverW-1:0]    mem [sor_pkg::CellCount];
  logic [sor_pkg::CoverW-1:0]    rdata_q;
  logic [sor_pkg::CellAddrW-1:0] wb_addr_q;
  logic                          wb_valid_q;

  logic                          we;
  logic [sor_pkg::CellAddrW-1:0] waddr;
  logic [sor_pkg::CoverW-1:0]    wdata;

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // write-back tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else begin
      wb_valid_q <= rd_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      wb_addr_q <= rd_addr_i;
    end
  end

  // saturating increment or clear
  always_comb begin
    if (clr_en_i) begin
      we    = 1'b1;
      waddr = clr_addr_i;
      wdata = '0;
    end else begin
      we    = wb_valid_q && (rdata_q != sor_pkg::CoverMax);
      waddr = wb_addr_q;
      wdata = rdata_q + sor_pkg::CoverW'(1);
    end
    stat_o.wb_pending = wb_valid_q;
    stat_o.hit_two    = wb_valid_q && (rdata_q == sor_pkg::CoverOne);
  end

endmodule

>>> rtl/core/segment_overlap_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// segment_overlap_rasterizer_unit
// Draws axis-aligned and 45 degree segments into a grid of saturating
// cover counts and reports the number of cells covered at least twice.
// ----------------------------------------------------------------------------
// draw word: one grid read-modify-write per cell through the grid memory
//   ports; walk, drain and done states lie between accept and result, and
//   the next word is taken only once the result register has loaded
// rejected word: no walk, straight to the done state and the result
// clear word: one memory write per cell over all 1048576 cells, then result
// reset: count cleared, a sweep zeroes the grid before accepts
module segment_overlap_rasterizer_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sor_pkg::sor_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sor_pkg::sor_out_t out_data_o
);

  typedef enum logic [4:0] {
    StClear = 5'b00001,
    StIdle  = 5'b00010,
    StWalk  = 5'b00100,
    StDrain = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [sor_pkg::CellAddrW-1:0] clr_cnt_q;
  logic                          clr_resp_q;
  logic                          rej_q;
  logic [sor_pkg::TotalW-1:0]    total_q;
  logic                          out_valid_q;
  sor_pkg::sor_out_t             out_data_q;

  logic                          accept;
  logic                          is_clear;
  logic                          seg_rejected;
  logic                          out_load;
  logic                          clr_last;
  sor_pkg::sor_walk_t            walk_cell;
  sor_pkg::sor_grid_stat_t       grid_stat;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign is_clear    = (in_data_i.action == sor_pkg::ActClear);
  assign clr_last    = (clr_cnt_q == sor_pkg::CellAddrW'(sor_pkg::CellCount - 1));
  assign out_load    = (state_q == StDone) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // segment walker
  sor_seg_walk u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && !is_clear && !seg_rejected),
    .adv_i      (state_q == StWalk),
    .seg_i      (in_data_i),
    .rejected_o (seg_rejected),
    .cell_o     (walk_cell)
  );

  // cover count memory
  sor_cover_grid u_grid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (state_q == StWalk),
    .rd_addr_i  (walk_cell.addr),
    .clr_en_i   (state_q == StClear),
    .clr_addr_i (clr_cnt_q),
    .stat_o     (grid_stat)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: begin
        if (clr_last) begin
          state_d = clr_resp_q ? StDone : StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          if (is_clear) begin
            state_d = StClear;
          end else if (seg_rejected) begin
            state_d = StDone;
          end else begin
            state_d = StWalk;
          end
        end
      end
      StWalk: begin
        if (walk_cell.last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StDone;
      end
      StDone: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_cnt_q  <= '0;
      clr_resp_q <= 1'b0;
      rej_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) begin
        clr_cnt_q <= clr_cnt_q + sor_pkg::CellAddrW'(1);
      end else begin
        clr_cnt_q <= '0;
      end
      if (accept) begin
        clr_resp_q <= is_clear;
        rej_q      <= !is_clear && seg_rejected;
      end
    end
  end

  // overlap count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (accept && is_clear) begin
      total_q <= '0;
    end else if (grid_stat.hit_two && (total_q != sor_pkg::TotalMax)) begin
      total_q <= total_q + sor_pkg::TotalW'(1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.overlap_cells <= total_q;
      out_data_q.rejected      <= rej_q;
    end
  end

  // no write-back may still be in flight when a new word can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !grid_stat.wb_pending)
    else $error("grid write-back pending while accepting");

  // count increments only come from the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grid_stat.hit_two |-> (state_q == StWalk || state_q == StDrain))
    else $error("cover hit outside of segment walk");

  // overlap count never falls except on a clear word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && is_clear) |=> total_q >= $past(total_q))
    else $error("overlap count decreased");

  // result is only loaded once the last write-back has landed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDone |-> !grid_stat.wb_pending)
    else $error("result ready before write-back done");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_overlap_rasterizer_unit. Segment and clear
// words go in through a queue-fed driver. An in-bench model keeps its own
// cover grid and overlap count and predicts each result word. The monitor
// compares every result word with the oldest prediction. Stimulus is a
// directed set, then random segments clustered in moving windows so that
// cells overlap, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  // slowest gap is the reset sweep or a clear, about one grid pass each
  localparam int StallLimit = 3 * sor_pkg::CellCount + 100000;
  localparam int ShowLimit  = 10;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  sor_pkg::sor_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  sor_pkg::sor_out_t out_data;

  // stimulus and prediction state
  sor_pkg::sor_in_t         segment_words_q[$];
  sor_pkg::sor_out_t        expected_overlaps_q[$];
  bit [sor_pkg::CoverW-1:0] cover_grid_m[sor_pkg::CellCount];
  bit [sor_pkg::TotalW-1:0] overlap_cnt  = '0;
  int                       words_in     = 0;
  int                       results_seen = 0;
  int                       err_cnt      = 0;
  int                       stall_cycles = 0;
  logic                     calm;

  segment_overlap_rasterizer_unit DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #2 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // no idling on either side for a stretch in the middle of the run
  assign calm = (words_in >= 150) && (words_in < 260);

  // append a word to the stimulus queue
  task automatic queue_word(sor_pkg::sor_in_t w);
    segment_words_q = {segment_words_q, w};
  endtask

  // model: walk the segment, bump saturating cover counts, count 1 -> 2 steps
  function automatic sor_pkg::sor_out_t rasterize_word(sor_pkg::sor_in_t w);
    sor_pkg::sor_out_t r;
    int sx, sy, ex, ey, dx, dy, steps, x, y, stx, sty, idx;
    r = '0;
    if (w.action == sor_pkg::ActClear) begin
      foreach (cover_grid_m[i]) cover_grid_m[i] = '0;
      overlap_cnt = '0;
      return r;
    end
    sx = w.start_x;
    sy = w.start_y;
    ex = w.end_x;
    ey = w.end_y;
    dx = (sx > ex) ? sx - ex : ex - sx;
    dy = (sy > ey) ? sy - ey : ey - sy;
    if (sx >= sor_pkg::GridSide || sy >= sor_pkg::GridSide ||
        ex >= sor_pkg::GridSide || ey >= sor_pkg::GridSide)
      r.rejected = 1'b1;
    else if (!(dx == 0 || dy == 0 || dx == dy))
      r.rejected = 1'b1;
    if (!r.rejected) begin
      steps = (dx > dy) ? dx : dy;
      stx = (ex > sx) ? 1 : ((ex < sx) ? -1 : 0);
      sty = (ey > sy) ? 1 : ((ey < sy) ? -1 : 0);
      x = sx;
      y = sy;
      for (int i = 0; i <= steps; i++) begin
        idx = y * sor_pkg::GridSide + x;
        if (cover_grid_m[idx] != sor_pkg::CoverMax) begin
          cover_grid_m[idx] = cover_grid_m[idx] + 1'b1;
          if (cover_grid_m[idx] == 2 && overlap_cnt != sor_pkg::TotalMax)
            overlap_cnt = overlap_cnt + 1'b1;
        end
        x += stx;
        y += sty;
      end
    end
    r.overlap_cells = overlap_cnt;
    return r;
  endfunction

  function automatic sor_pkg::sor_in_t seg(int sx, int sy, int ex, int ey);
    sor_pkg::sor_in_t w;
    w = '0;
    w.action  = sor_pkg::ActDraw;
    w.start_x = sor_pkg::CoordW'(sx);
    w.start_y = sor_pkg::CoordW'(sy);
    w.end_x   = sor_pkg::CoordW'(ex);
    w.end_y   = sor_pkg::CoordW'(ey);
    return w;
  endfunction

  // random segment near a window so that segments cross each other
  function automatic sor_pkg::sor_in_t random_segment(int win_x, int win_y);
    sor_pkg::sor_in_t w;
    int kind, len, x0, y0, x1, y1;
    kind = $urandom_range(0, 99);
    len  = ($urandom_range(0, 49) == 0) ? $urandom_range(0, sor_pkg::GridSide - 1)
                                         : $urandom_range(0, 40);
    x0 = win_x + $urandom_range(0, 63);
    y0 = win_y + $urandom_range(0, 63);
    if (x0 > sor_pkg::GridSide - 1 - len) x0 = sor_pkg::GridSide - 1 - len;
    if (y0 > sor_pkg::GridSide - 1 - len) y0 = sor_pkg::GridSide - 1 - len;
    x1 = x0;
    y1 = y0;
    if (kind < 25) begin
      x1 = x0 + len;
    end else if (kind < 50) begin
      y1 = y0 + len;
    end else if (kind < 70) begin
      x1 = x0 + len;
      y1 = y0 + len;
    end else if (kind < 85) begin
      // anti-diagonal: x rises while y falls
      x1 = x0 + len;
      y1 = y0;
      y0 = y0 + len;
    end else if (kind >= 92) begin
      // anywhere on the grid, mostly a bad slope
      x0 = $urandom_range(0, sor_pkg::GridSide - 1);
      y0 = $urandom_range(0, sor_pkg::GridSide - 1);
      x1 = $urandom_range(0, sor_pkg::GridSide - 1);
      y1 = $urandom_range(0, sor_pkg::GridSide - 1);
    end
    if ($urandom_range(0, 1))
      w = seg(x1, y1, x0, y0);
    else
      w = seg(x0, y0, x1, y1);
    return w;
  endfunction

  task automatic check_result(sor_pkg::sor_out_t got);
    sor_pkg::sor_out_t want;
    if (expected_overlaps_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= ShowLimit)
        $display("unexpected result word %0d: overlap_cells %0d rejected %0b",
                 results_seen, got.overlap_cells, got.rejected);
      return;
    end
    want = expected_overlaps_q.pop_front();
    if (got.overlap_cells !== want.overlap_cells || got.rejected !== want.rejected) begin
      err_cnt++;
      if (err_cnt <= ShowLimit)
        $display("result word %0d: overlap_cells exp %0d got %0d, rejected exp %0b got %0b",
                 results_seen, want.overlap_cells, got.overlap_cells,
                 want.rejected, got.rejected);
    end
  endtask

  // driver: predict on accept, then present the next word or idle
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_overlaps_q = {expected_overlaps_q, rasterize_word(in_data)};
        words_in <= words_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (segment_words_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          in_valid <= 1'b1;
          in_data  <= segment_words_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side backpressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_result(out_data);
      results_seen <= results_seen + 1;
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("FAIL segment_overlap_rasterizer_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic drain();
    while (segment_words_q.size() != 0 || in_valid || expected_overlaps_q.size() != 0)
      @(negedge clk);
  endtask

  // stimulus
  initial begin
    sor_pkg::sor_in_t clr;
    int win_x, win_y;

    // full-length lines along every direction, then reversed repeats
    queue_word(seg(0, 0, sor_pkg::GridSide - 1, 0));
    queue_word(seg(sor_pkg::GridSide - 1, 0, sor_pkg::GridSide - 1, sor_pkg::GridSide - 1));
    queue_word(seg(0, 0, sor_pkg::GridSide - 1, sor_pkg::GridSide - 1));
    queue_word(seg(sor_pkg::GridSide - 1, 0, 0, sor_pkg::GridSide - 1));
    queue_word(seg(sor_pkg::GridSide - 1, 0, 0, 0));
    queue_word(seg(sor_pkg::GridSide - 1, sor_pkg::GridSide - 1, sor_pkg::GridSide - 1, 0));
    queue_word(seg(0, sor_pkg::GridSide - 1, sor_pkg::GridSide - 1, 0));
    // single point hit four times: count rises once, cover saturates
    repeat (4) queue_word(seg(5, 7, 5, 7));
    // bad slopes, grid left alone
    queue_word(seg(0, 0, 3, 5));
    queue_word(seg(sor_pkg::GridSide - 1, sor_pkg::GridSide - 1, 0, 1));
    queue_word(seg(1, 0, 0, sor_pkg::GridSide - 1));
    // clear with all coordinate bits set
    clr = '1;
    clr.action = sor_pkg::ActClear;
    queue_word(clr);
    // crossing diagonals after the clear
    queue_word(seg(0, 0, 2, 2));
    queue_word(seg(2, 0, 0, 2));
    queue_word(seg(1, 0, 1, 2));
    queue_word(seg(0, 1, 2, 1));
    queue_word(seg(sor_pkg::GridSide - 1, sor_pkg::GridSide - 1,
                   sor_pkg::GridSide - 1, sor_pkg::GridSide - 1));
    drain();

    // random segments, window moves every 40 words
    for (int i = 0; i < 400; i++) begin
      if (i % 40 == 0) begin
        win_x = $urandom_range(0, sor_pkg::GridSide - 64);
        win_y = $urandom_range(0, sor_pkg::GridSide - 64);
      end
      @(negedge clk);
      queue_word(random_segment(win_x, win_y));
      // sender holds off until every result is back
      if (i == 200) drain();
    end
    drain();
    repeat (64) @(negedge clk);

    if (err_cnt == 0) begin
      $display("PASS segment_overlap_rasterizer_unit");
    end else begin
      $display("FAIL segment_overlap_rasterizer_unit");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sor_pkg.sv
rtl/core/sor_seg_walk.sv
rtl/core/sor_cover_grid.sv
rtl/core/segment_overlap_rasterizer_unit.sv
test/tb_top.sv
